// ----- rtl/core/ssih_pkg.sv -----
// Shared widths, register codes and stage types for the segment crossing
// height unit. No dependencies.
package ssih_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CW   = 33;
  localparam int XW   = 2 * CW + 1;
  localparam int DW   = XW;
  localparam int QW   = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 1;
  localparam int NW   = DW + FRAC_BITS;
  localparam int RW   = DW + QW;
  localparam int MW   = (NW > RW) ? NW : RW;
  localparam int TW   = QW + 1;
  localparam int PW   = CW + TW;
  localparam int DXW  = PW - FRAC_BITS;
  localparam int ZW   = DXW + 1;
  localparam int SQW  = 2 * DXW;
  localparam int SW   = SQW + 1;

  localparam int IDX_W = 8;
  localparam int IN_W  = 384;
  localparam int OUT_W = 72;

  localparam logic [IDX_W-1:0] REG_THRESHOLD = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_TOLERANCE = IDX_W'(1);
  localparam logic [31:0]      THR_RESET     = 32'd429497;
  localparam logic [15:0]      TOL_RESET     = 16'd7;
  localparam logic [QW-1:0]    ONE_Q         = QW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [CW-1:0] rdx;
    logic [CW-1:0] rdy;
    logic [CW-1:0] dz;
    logic [31:0]   rsz;
    logic [33:0]   zlo;
    logic [33:0]   zhi;
  } side_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [RW-1:0] d;
    logic [QW-1:0] q;
    logic          neg;
  } dv_t;

  typedef struct packed {
    side_t side;
    dv_t   t;
    dv_t   u;
    logic  miss;
  } stage_t;

endpackage

// ----- rtl/core/ssih_front.sv -----
// Front pipeline: deltas, cross products, magnitudes and divider setup.
// Depends on ssih_pkg.
module ssih_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ce,
  input  logic                    in_valid,
  input  logic [ssih_pkg::IN_W-1:0] in_data,
  input  logic [31:0]             thr,
  output logic                    out_valid,
  output ssih_pkg::stage_t        out_st
);
  import ssih_pkg::*;

  function automatic logic [CW-1:0] dif(logic [31:0] a, logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  logic [31:0] f [12];
  always_comb begin
    for (int i = 0; i < 12; i++) f[i] = in_data[32*i +: 32];
  end

  logic          a_v, b_v, c_v, d_v;
  logic [CW-1:0] a_rdx, a_rdy, a_wdx, a_wdy, a_relx, a_rely;
  side_t         a_side, b_side, c_side, d_side;
  logic [65:0]   b_p [6];
  logic [XW-1:0] c_den, c_nt, c_nu;
  logic [DW-1:0] d_dm, d_nt, d_nu;
  logic          d_tneg, d_uneg;

  logic [31:0] zmin, zmax;
  always_comb begin
    if ($signed(f[8]) < $signed(f[11])) begin
      zmin = f[8];
      zmax = f[11];
    end else begin
      zmin = f[11];
      zmax = f[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      out_valid <= d_v;
    end
  end

  logic [MW-1:0] e_nt, e_nu, e_lim;
  logic          e_par;
  always_comb begin
    e_nt  = MW'({d_nt, {FRAC_BITS{1'b0}}});
    e_nu  = MW'({d_nu, {FRAC_BITS{1'b0}}});
    e_lim = MW'({d_dm, {QW{1'b0}}});
    e_par = (d_dm == '0) || (d_dm < DW'(thr));
  end

  // tolerance is applied to the z span in the back end
  always_ff @(posedge clk) begin
    if (ce) begin
      a_rdx  <= dif(f[3], f[0]);
      a_rdy  <= dif(f[4], f[1]);
      a_wdx  <= dif(f[9], f[6]);
      a_wdy  <= dif(f[10], f[7]);
      a_relx <= dif(f[6], f[0]);
      a_rely <= dif(f[7], f[1]);
      a_side.rdx <= dif(f[3], f[0]);
      a_side.rdy <= dif(f[4], f[1]);
      a_side.dz  <= dif(f[5], f[2]);
      a_side.rsz <= f[2];
      a_side.zlo <= {{2{zmin[31]}}, zmin};
      a_side.zhi <= {{2{zmax[31]}}, zmax};

      b_p[0] <= $signed(a_rdx) * $signed(a_wdy);
      b_p[1] <= $signed(a_rdy) * $signed(a_wdx);
      b_p[2] <= $signed(a_relx) * $signed(a_wdy);
      b_p[3] <= $signed(a_rely) * $signed(a_wdx);
      b_p[4] <= $signed(a_relx) * $signed(a_rdy);
      b_p[5] <= $signed(a_rely) * $signed(a_rdx);
      b_side <= a_side;

      c_den  <= {b_p[0][65], b_p[0]} - {b_p[1][65], b_p[1]};
      c_nt   <= {b_p[2][65], b_p[2]} - {b_p[3][65], b_p[3]};
      c_nu   <= {b_p[4][65], b_p[4]} - {b_p[5][65], b_p[5]};
      c_side <= b_side;

      d_dm   <= c_den[XW-1] ? -c_den : c_den;
      d_nt   <= c_nt[XW-1] ? -c_nt : c_nt;
      d_nu   <= c_nu[XW-1] ? -c_nu : c_nu;
      d_tneg <= c_nt[XW-1] ^ c_den[XW-1];
      d_uneg <= c_nu[XW-1] ^ c_den[XW-1];
      d_side <= c_side;

      out_st.side  <= d_side;
      out_st.t.r   <= e_nt[RW-1:0];
      out_st.u.r   <= e_nu[RW-1:0];
      out_st.t.d   <= RW'({d_dm, {(QW-1){1'b0}}});
      out_st.u.d   <= RW'({d_dm, {(QW-1){1'b0}}});
      out_st.t.q   <= '0;
      out_st.u.q   <= '0;
      out_st.t.neg <= d_tneg;
      out_st.u.neg <= d_uneg;
      out_st.miss  <= e_par || (e_nt >= e_lim) || (e_nu >= e_lim);
    end
  end

endmodule

// ----- rtl/core/ssih_div_step.sv -----
// One restoring division step for both the t and u quotients.
// Depends on ssih_pkg.
module ssih_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  ssih_pkg::stage_t in_st,
  output logic             out_valid,
  output ssih_pkg::stage_t out_st
);
  import ssih_pkg::*;

  function automatic dv_t step(dv_t x);
    dv_t y;
    y = x;
    if (x.r >= x.d) begin
      y.r = x.r - x.d;
      y.q = {x.q[QW-2:0], 1'b1};
    end else begin
      y.q = {x.q[QW-2:0], 1'b0};
    end
    y.d = x.d >> 1;
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_st.side <= in_st.side;
      out_st.miss <= in_st.miss;
      out_st.t    <= step(in_st.t);
      out_st.u    <= step(in_st.u);
    end
  end

endmodule

// ----- rtl/core/ssih_back.sv -----
// Back pipeline: window test, height interpolation, squared distance.
// Depends on ssih_pkg.
module ssih_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  ssih_pkg::stage_t in_st,
  input  logic [15:0]      tol,
  output logic             out_valid,
  output logic             hit,
  output logic [63:0]      dist_sq
);
  import ssih_pkg::*;

  logic          a_v, b_v, c_v, d_v;
  logic          a_miss, b_miss, c_miss, d_miss;
  side_t         a_side, b_side;
  logic [TW-1:0] a_t;
  logic [PW-1:0] b_pz, b_px, b_py;
  logic [DXW-1:0] c_dx, c_dy;
  logic [SQW-1:0] d_sx, d_sy;

  logic [QW-1:0] lim_t, lim_u;
  logic [TW-1:0] tq;
  always_comb begin
    lim_t = in_st.t.neg ? QW'(tol) : ONE_Q + QW'(tol);
    lim_u = in_st.u.neg ? QW'(tol) : ONE_Q + QW'(tol);
    tq    = in_st.t.neg ? -{1'b0, in_st.t.q} : {1'b0, in_st.t.q};
  end

  logic [PW-1:0]  sz, sx, sy;
  logic [ZW-1:0]  z, zlo, zhi;
  always_comb begin
    sz  = PW'($signed(b_pz) >>> FRAC_BITS);
    sx  = PW'($signed(b_px) >>> FRAC_BITS);
    sy  = PW'($signed(b_py) >>> FRAC_BITS);
    z   = ZW'($signed(b_side.rsz)) + ZW'($signed(sz[DXW-1:0]));
    zlo = ZW'($signed(b_side.zlo)) - ZW'(tol);
    zhi = ZW'($signed(b_side.zhi)) + ZW'(tol);
  end

  logic [SW-1:0] sum;
  assign sum = SW'(d_sx) + SW'(d_sy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_side <= in_st.side;
      a_t    <= tq;
      a_miss <= in_st.miss || (in_st.t.q > lim_t) || (in_st.u.q > lim_u);

      b_pz   <= $signed(a_side.dz) * $signed(a_t);
      b_px   <= $signed(a_side.rdx) * $signed(a_t);
      b_py   <= $signed(a_side.rdy) * $signed(a_t);
      b_side <= a_side;
      b_miss <= a_miss;

      c_dx   <= sx[DXW-1:0];
      c_dy   <= sy[DXW-1:0];
      c_miss <= b_miss || ($signed(z) < $signed(zlo)) || ($signed(z) > $signed(zhi));

      d_sx   <= $signed(c_dx) * $signed(c_dx);
      d_sy   <= $signed(c_dy) * $signed(c_dy);
      d_miss <= c_miss;

      hit <= !d_miss;
      if (d_miss) begin
        dist_sq <= '0;
      end else if (|sum[SW-1:64]) begin
        dist_sq <= '1;
      end else begin
        dist_sq <= sum[63:0];
      end
    end
  end

endmodule

// ----- rtl/core/segment_segment_intersect_height_unit.sv -----
// Top level of the segment crossing height unit: config registers and the
// pipeline. Depends on ssih_pkg, ssih_front, ssih_div_step, ssih_back.
//
// Usage:
//   s_* carries one query item: twelve signed Q16.16 words in tdata, from
//   the low bits up ray_start_x/y/z, ray_end_x/y/z, wall_start_x/y/z,
//   wall_end_x/y/z. m_* returns one result item per query, in order.
//   cfg_* writes parallel_threshold (index 0) or edge_tolerance (index 1);
//   other indexes are dropped. Write only while the pipeline is empty.
// Throughput: one item per cycle while the pipeline is not stalled.
//   The t and u dividers produce one restoring quotient bit per stage.
// Reset: empties the pipeline and loads the register reset values.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready is
//   low; s_tready falls in the same cycle, so no item is lost or repeated.
module segment_segment_intersect_height_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ssih_pkg::IN_W-1:0]   s_tdata,   // 12 x 32-bit fields, see above
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ssih_pkg::OUT_W-1:0]  m_tdata,   // [0] hit, [64:1] dist_sq, zero pad
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssih_pkg::IDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import ssih_pkg::*;

  logic [31:0] thr;
  logic [15:0] tol;
  logic        ce;
  logic        hit;
  logic [63:0] dist_sq;

  stage_t st [QW+1];
  logic   sv [QW+1];

  assign cfg_ready = 1'b1;
  assign ce        = m_tready || !m_tvalid;
  assign s_tready  = ce;
  assign m_tdata   = OUT_W'({dist_sq, hit});

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      tol <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_THRESHOLD) thr <= cfg_data;
      if (cfg_index == REG_TOLERANCE) tol <= cfg_data[15:0];
    end
  end

  ssih_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .thr      (thr),
    .out_valid(sv[0]),
    .out_st   (st[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    ssih_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .ce       (ce),
      .in_valid (sv[k]),
      .in_st    (st[k]),
      .out_valid(sv[k+1]),
      .out_st   (st[k+1])
    );
  end

  ssih_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (sv[QW]),
    .in_st    (st[QW]),
    .tol      (tol),
    .out_valid(m_tvalid),
    .hit      (hit),
    .dist_sq  (dist_sq)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !hit |-> dist_sq == '0)
    else $error("miss result with nonzero distance");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pipeline moved during stall");

endmodule

// ----- bench/ssih_checker.sv -----
// Checker for the segment crossing height unit: watches query, result and
// register write channels, predicts each result and compares in order.
// Depends on ssih_pkg.
module ssih_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [ssih_pkg::IN_W-1:0]   s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [ssih_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ssih_pkg::IDX_W-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssih_pkg::*;

  typedef struct packed {
    logic [63:0] dist_sq;
    logic        hit;
  } crossing_t;

  logic [31:0] threshold;
  logic [15:0] tolerance;
  crossing_t   expected_q[$];

  // Quotient of num/den scaled by one, kept only inside the tolerance window.
  function automatic bit param_ok(input logic signed [127:0] num,
                                  input logic signed [127:0] den,
                                  input logic [15:0] tol,
                                  output logic signed [127:0] p);
    logic [127:0] n, d, q, lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    n = n << FRAC_BITS;
    d = (den < 0) ? -den : den;
    q = n / d;
    lim = neg ? 128'(tol) : (128'(1) << FRAC_BITS) + 128'(tol);
    p = neg ? -$signed(q) : $signed(q);
    return q <= lim;
  endfunction

  function automatic crossing_t crossing_of(input logic [IN_W-1:0] q,
                                            input logic [31:0] thr,
                                            input logic [15:0] tol);
    logic signed [127:0] v[12];
    logic signed [127:0] rdx, rdy, wdx, wdy, relx, rely, den, dm, t, u;
    logic signed [127:0] z, zlo, zhi, dx, dy, tl;
    logic [127:0] sum;
    crossing_t r;
    r = '0;
    for (int i = 0; i < 12; i++) v[i] = $signed(q[32*i +: 32]);
    tl = {112'b0, tol};
    rdx = v[3] - v[0];
    rdy = v[4] - v[1];
    wdx = v[9] - v[6];
    wdy = v[10] - v[7];
    relx = v[6] - v[0];
    rely = v[7] - v[1];
    den = rdx * wdy - rdy * wdx;
    dm = (den < 0) ? -den : den;
    if (dm == 0 || dm < $signed({96'b0, thr})) return r;
    if (!param_ok(relx * wdy - rely * wdx, den, tol, t)) return r;
    if (!param_ok(relx * rdy - rely * rdx, den, tol, u)) return r;
    z = v[2] + (((v[5] - v[2]) * t) >>> FRAC_BITS);
    zlo = ((v[8] < v[11]) ? v[8] : v[11]) - tl;
    zhi = ((v[8] > v[11]) ? v[8] : v[11]) + tl;
    if (z < zlo || z > zhi) return r;
    dx = (rdx * t) >>> FRAC_BITS;
    dy = (rdy * t) >>> FRAC_BITS;
    sum = dx * dx + dy * dy;
    r.hit = 1'b1;
    r.dist_sq = (sum[127:64] != 0) ? '1 : sum[63:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    crossing_t e, a;
    if (rst) begin
      threshold <= THR_RESET;
      tolerance <= TOL_RESET;
      expected_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD) threshold <= cfg_data;
        else if (cfg_index == REG_TOLERANCE) tolerance <= cfg_data[15:0];
      end
      if (s_tvalid && s_tready) expected_q.push_back(crossing_of(s_tdata, threshold, tolerance));
      if (m_tvalid && m_tready) begin
        a.hit = m_tdata[0];
        a.dist_sq = m_tdata[64:1];
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result item with none expected: hit %0b dist_sq %h",
                     $realtime, a.hit, a.dist_sq);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_q.pop_front();
          if (a.hit !== e.hit || a.dist_sq !== e.dist_sq) begin
            if (mismatches < 10)
              $display("%0t: hit %0b/%0b dist_sq %h/%h (expected/actual)", $realtime,
                       e.hit, a.hit, e.dist_sq, a.dist_sq);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ----- bench/segment_segment_intersect_height_unit_tb.sv -----
// Testbench top for the segment crossing height unit: clock, reset,
// query and register stimulus, verdict. Depends on ssih_pkg, ssih_checker and the DUT.
module segment_segment_intersect_height_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssih_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(2);
  localparam int ONE = 1 << FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
  logic s_tready, m_tvalid, cfg_ready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [OUT_W-1:0] m_tdata;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  bit calm = 0;
  int mismatches, pending, cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  segment_segment_intersect_height_unit DUT (.*);

  ssih_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    m_tready <= calm || ($urandom_range(99) >= 33);
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_query(input int f[12]);
    while (!calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 12; i++) s_tdata[32*i +: 32] <= f[i];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int scaled(input int bits);
    return $signed($urandom()) >>> (32 - bits);
  endfunction

  // Crossing-prone geometry at a random scale, z span mostly covering the probe.
  task automatic random_query();
    int f[12];
    int k, lo, hi;
    if ($urandom_range(99) < 15) begin
      for (int i = 0; i < 12; i++) f[i] = $urandom();
    end else begin
      k = $urandom_range(31, 4);
      for (int i = 0; i < 12; i++) f[i] = scaled(k);
      if ($urandom_range(1)) begin
        f[6] = f[0] + scaled(k - 1);
        f[9] = f[3] - scaled(k - 1);
      end
      if ($urandom_range(99) < 70) begin
        lo = (f[2] < f[5]) ? f[2] : f[5];
        hi = (f[2] > f[5]) ? f[2] : f[5];
        f[8] = (lo < -2147483647 + 256) ? lo : lo - $urandom_range(255);
        f[11] = (hi > 2147483646 - 256) ? hi : hi + $urandom_range(255);
      end
    end
    send_query(f);
  endtask

  task automatic directed_queries();
    int mx = 32'h7fffffff, mn = 32'h80000000;
    send_query('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx});
    send_query('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn});
    send_query('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    // parallel
    send_query('{0, 0, 0, 2*ONE, 0, 0, 0, ONE, 0, 2*ONE, ONE, ONE});
    // plain crossing, then height miss above
    send_query('{0, 0, 0, 2*ONE, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE});
    send_query('{0, 0, 5*ONE, 2*ONE, 0, 5*ONE, ONE, -ONE, -ONE, ONE, ONE, ONE});
    // crossing exactly at the probe end, just past it, just before the start, well before it
    send_query('{0, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE});
    send_query('{0, 0, 0, ONE - 3, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE});
    send_query('{0, 0, 0, ONE, 0, 0, -3, -ONE, -ONE, -3, ONE, ONE});
    send_query('{0, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, -ONE, ONE, ONE});
    // diagonal across the full range: large distance
    send_query('{mn, mn, 0, mx, mx, 0, mn, mx, mn, mx, mn, mx});
    send_query('{mn, mn, mn, mx, mx, mx, mn, mx, 0, mx, mn, 0});
    // huge quotient: short probe, far crossing; then a mid crossing and a coincident pair
    send_query('{0, 0, 0, 1, 0, 0, mx, mn, 0, mx, mx, 0});
    send_query('{0, 0, 0, ONE, 1, 0, ONE/2, -ONE, -ONE, ONE/2, ONE, ONE});
    send_query('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                 32'h55555555, 32'haaaaaaaa});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    directed_queries();
    for (int i = 0; i < 100; i++) random_query();
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_TOLERANCE, 32'd0);
    directed_queries();
    calm = 1;
    for (int i = 0; i < 100; i++) random_query();
    calm = 0;
    write_reg(REG_THRESHOLD, 32'hffffffff);
    write_reg(REG_TOLERANCE, 32'h0000ffff);
    directed_queries();
    for (int i = 0; i < 80; i++) random_query();
    write_reg(REG_THRESHOLD, $urandom_range(1000));
    write_reg(REG_TOLERANCE, $urandom());
    write_reg(REG_UNUSED, $urandom());
    for (int i = 0; i < 120; i++) random_query();
    write_reg(REG_THRESHOLD, THR_RESET);
    write_reg(REG_TOLERANCE, TOL_RESET);
    for (int i = 0; i < 100; i++) random_query();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
